[sv/blat_pkg.sv]
// ----------------------------------------------------------------------------
// blat_pkg
// Shared types, constants and the signature check of the advertisement
// tracker classifier.
// ----------------------------------------------------------------------------
package blat_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned KindW      = 2;
  localparam int unsigned IdW        = 16;
  localparam int unsigned HeadW      = 24;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 16;

  localparam logic [ByteW-1:0] TypeMfrData  = 8'hFF;
  localparam logic [ByteW-1:0] TypeSvcData  = 8'h16;
  localparam logic [ByteW-1:0] MaxParsed    = 8'hFF;
  localparam logic [ByteW-1:0] MfrMinLen    = 8'd4;
  localparam logic [ByteW-1:0] SvcMinLen    = 8'd2;

  localparam logic [IdW-1:0]   RstFindmyId  = 16'h004C;
  localparam logic [ByteW-1:0] RstFindmySub = 8'h12;
  localparam logic [IdW-1:0]   RstTagId     = 16'h0075;
  localparam logic [IdW-1:0]   RstUuidA     = 16'hFEED;
  localparam logic [IdW-1:0]   RstUuidB     = 16'hFD84;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FINDMY_ID  = 3'd0,
    REG_FINDMY_SUB = 3'd1,
    REG_TAG_ID     = 3'd2,
    REG_UUID_A     = 3'd3,
    REG_UUID_B     = 3'd4
  } cfg_reg_e;

  typedef enum logic [KindW-1:0] {
    KIND_NONE    = 2'd0,
    KIND_FINDMY  = 2'd1,
    KIND_VENDOR  = 2'd2,
    KIND_SERVICE = 2'd3
  } kind_e;

  typedef struct packed {
    logic [IdW-1:0]   findmy_id;
    logic [ByteW-1:0] findmy_sub;
    logic [IdW-1:0]   tag_id;
    logic [IdW-1:0]   uuid_a;
    logic [IdW-1:0]   uuid_b;
  } cfg_t;

  // Judges one completed structure; an earlier match is kept.
  function automatic kind_e judge(kind_e found, logic [ByteW-1:0] stype,
                                  logic [ByteW-1:0] slen, logic [HeadW-1:0] head,
                                  cfg_t cfg);
    logic [IdW-1:0]   id;
    logic [ByteW-1:0] third;
    kind_e            kind;
    id    = head[IdW-1:0];
    third = head[HeadW-1:IdW];
    kind  = found;
    if (found == KIND_NONE) begin
      if (stype == TypeMfrData && slen >= MfrMinLen) begin
        if (id == cfg.findmy_id && third == cfg.findmy_sub) begin
          kind = KIND_FINDMY;
        end else if (id == cfg.tag_id) begin
          kind = KIND_VENDOR;
        end
      end
      if (stype == TypeSvcData && slen >= SvcMinLen &&
          (id == cfg.uuid_a || id == cfg.uuid_b)) begin
        kind = KIND_SERVICE;
      end
    end
    return kind;
  endfunction

endpackage

[sv/blat_if.sv]
// ----------------------------------------------------------------------------
// blat_if
// Valid/ready channels of the tracker classifier: advertisement bytes,
// classification results and configuration writes.
// ----------------------------------------------------------------------------
interface blat_adv_if;
  import blat_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] adv_byte;
  logic             end_of_packet;
  modport source (output valid, output adv_byte, output end_of_packet, input ready);
  modport sink   (input valid, input adv_byte, input end_of_packet, output ready);
endinterface

interface blat_res_if;
  import blat_pkg::*;
  logic             valid;
  logic             ready;
  logic             tracker_found;
  logic [KindW-1:0] tracker_kind;
  modport source (output valid, output tracker_found, output tracker_kind, input ready);
  modport sink   (input valid, input tracker_found, input tracker_kind, output ready);
endinterface

interface blat_cfg_if;
  import blat_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/blat_cfg_regs.sv]
// ----------------------------------------------------------------------------
// blat_cfg_regs
// Signature registers, written one at a time through the configuration
// channel.
// ----------------------------------------------------------------------------
module blat_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  blat_cfg_if.sink      cfg_i,
  output blat_pkg::cfg_t cfg_o
);
  import blat_pkg::*;

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.findmy_id  <= RstFindmyId;
      cfg_q.findmy_sub <= RstFindmySub;
      cfg_q.tag_id     <= RstTagId;
      cfg_q.uuid_a     <= RstUuidA;
      cfg_q.uuid_b     <= RstUuidB;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_FINDMY_ID:  cfg_q.findmy_id  <= cfg_i.data;
        REG_FINDMY_SUB: cfg_q.findmy_sub <= cfg_i.data[ByteW-1:0];
        REG_TAG_ID:     cfg_q.tag_id     <= cfg_i.data;
        REG_UUID_A:     cfg_q.uuid_a     <= cfg_i.data;
        REG_UUID_B:     cfg_q.uuid_b     <= cfg_i.data;
        default: ;
      endcase
    end
  end

endmodule

[sv/blat_parser.sv]
// ----------------------------------------------------------------------------
// blat_parser
// Length-type-value walker: holds the per-packet parse state and gives the
// classification of the packet on its last byte.
// ----------------------------------------------------------------------------
module blat_parser (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   take_i,
  input  logic [blat_pkg::ByteW-1:0] byte_i,
  input  logic                   eop_i,
  input  blat_pkg::cfg_t         cfg_i,
  output blat_pkg::kind_e        kind_o
);
  import blat_pkg::*;

  typedef enum logic [1:0] {
    PH_LEN     = 2'd0,
    PH_TYPE    = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] len_q, len_d;
  logic [ByteW-1:0] left_q, left_d;
  logic [ByteW-1:0] type_q, type_d;
  logic [HeadW-1:0] head_q, head_d;
  logic             stop_q, stop_d;
  kind_e            found_q, found_d;
  logic [ByteW-1:0] count_q, count_d;
  logic [ByteW-1:0] pos;

  assign pos = len_q - left_q;

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    left_d  = left_q;
    type_d  = type_q;
    head_d  = head_q;
    stop_d  = stop_q;
    found_d = found_q;
    count_d = count_q;
    if (count_q < MaxParsed) begin
      count_d = count_q + 8'd1;
      if (!stop_q) begin
        unique case (phase_q)
          PH_LEN: begin
            if (byte_i == '0) begin
              stop_d = 1'b1;
            end else begin
              len_d   = byte_i - 8'd1;
              left_d  = byte_i - 8'd1;
              head_d  = '0;
              phase_d = PH_TYPE;
            end
          end
          PH_TYPE: begin
            type_d = byte_i;
            if (left_q == '0) begin
              found_d = judge(found_q, byte_i, len_q, head_q, cfg_i);
              phase_d = PH_LEN;
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            if (pos < 8'd3) begin
              case (pos[1:0])
                2'd0:    head_d[7:0]   = head_q[7:0]   | byte_i;
                2'd1:    head_d[15:8]  = head_q[15:8]  | byte_i;
                default: head_d[23:16] = head_q[23:16] | byte_i;
              endcase
            end
            left_d = left_q - 8'd1;
            if (left_q == 8'd1) begin
              found_d = judge(found_q, type_q, len_q, head_d, cfg_i);
              phase_d = PH_LEN;
            end
          end
          default: phase_d = PH_LEN;
        endcase
      end
    end
  end

  assign kind_o = found_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEN;
      len_q   <= '0;
      left_q  <= '0;
      type_q  <= '0;
      head_q  <= '0;
      stop_q  <= 1'b0;
      found_q <= KIND_NONE;
      count_q <= '0;
    end else if (take_i) begin
      if (eop_i) begin
        phase_q <= PH_LEN;
        len_q   <= '0;
        left_q  <= '0;
        type_q  <= '0;
        head_q  <= '0;
        stop_q  <= 1'b0;
        found_q <= KIND_NONE;
        count_q <= '0;
      end else begin
        phase_q <= phase_d;
        len_q   <= len_d;
        left_q  <= left_d;
        type_q  <= type_d;
        head_q  <= head_d;
        stop_q  <= stop_d;
        found_q <= found_d;
        count_q <= count_d;
      end
    end
  end

endmodule

[sv/ble_adv_tracker_classifier.sv]
// ----------------------------------------------------------------------------
// ble_adv_tracker_classifier
// Classifies BLE advertisements as tracker tags from their raw bytes.
// ----------------------------------------------------------------------------
// Bytes of an advertisement enter one per request, one per cycle at full
// rate; a byte goes through an input register and then the parser, and
// the byte that carries end_of_packet leaves one result request in the
// output register.
// The output register decouples the two sides: bytes keep
// flowing while a result waits, and only a second last byte stalls behind
// an untaken result. Configuration writes are taken in any cycle and should
// be made between packets.
module ble_adv_tracker_classifier (
  input  logic       clk_i,
  input  logic       rst_ni,
  blat_adv_if.sink   adv_i,
  blat_res_if.source result_o,
  blat_cfg_if.sink   cfg_i
);
  import blat_pkg::*;

  cfg_t             cfg;
  kind_e            kind;
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_eop_q;
  logic             out_valid_q;
  kind_e            out_kind_q;
  logic             out_free;
  logic             proc_fire;

  assign out_free  = !out_valid_q || result_o.ready;
  assign proc_fire = in_valid_q && (!in_eop_q || out_free);
  assign adv_i.ready = !in_valid_q || proc_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (adv_i.ready) begin
      in_valid_q <= adv_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.ready && adv_i.valid) begin
      in_byte_q <= adv_i.adv_byte;
      in_eop_q  <= adv_i.end_of_packet;
    end
  end

  blat_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  blat_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (proc_fire),
    .byte_i (in_byte_q),
    .eop_i  (in_eop_q),
    .cfg_i  (cfg),
    .kind_o (kind)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_kind_q  <= KIND_NONE;
    end else if (proc_fire && in_eop_q) begin
      out_valid_q <= 1'b1;
      out_kind_q  <= kind;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.tracker_kind  = out_kind_q;
  assign result_o.tracker_found = (out_kind_q != KIND_NONE);

  a_result_from_last_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(proc_fire && in_eop_q))
    else $error("result request without a last byte");

  a_pending_byte_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !proc_fire) |=> (in_valid_q && $stable(in_byte_q) && $stable(in_eop_q)))
    else $error("stalled byte lost from the input register");

  a_no_result_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !result_o.ready) |-> !(proc_fire && in_eop_q))
    else $error("result overwritten before it was taken");

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the advertisement tracker classifier. Random and
// directed advertisements go in one byte request at a time. A parser model
// kept in step with the accepted bytes predicts the verdict of each
// packet. Every result request is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import blat_pkg::*;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned LongHold   = 300;

  typedef enum logic [1:0] {
    SEEK_LEN,
    SEEK_TYPE,
    IN_BODY
  } parse_phase_e;

  typedef struct packed {
    logic [ByteW-1:0] value;
    logic             last;
  } adv_item_t;

  typedef struct packed {
    logic  found;
    kind_e kind;
  } verdict_t;

  logic clk_i;
  logic rst_ni;

  blat_adv_if adv_if ();
  blat_res_if res_if ();
  blat_cfg_if cfg_if ();

  ble_adv_tracker_classifier u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  adv_item_t        bytes_pending[$];
  verdict_t         verdicts_due[$];
  logic [ByteW-1:0] pkt_bytes[$];
  adv_item_t        next_item;

  cfg_t cfg_model = '{findmy_id: RstFindmyId, findmy_sub: RstFindmySub, tag_id: RstTagId,
                      uuid_a: RstUuidA, uuid_b: RstUuidB};

  parse_phase_e     trk_phase   = SEEK_LEN;
  logic [ByteW-1:0] trk_len     = '0;
  logic [ByteW-1:0] trk_left    = '0;
  logic [ByteW-1:0] trk_type    = '0;
  logic [HeadW-1:0] trk_head    = '0;
  logic             trk_stopped = 1'b0;
  kind_e            trk_found   = KIND_NONE;
  logic [ByteW-1:0] trk_count   = '0;

  logic        adv_fire       = 1'b0;
  logic        sender_quiet   = 1'b0;
  logic        receiver_quiet = 1'b0;
  logic        hold_off_req   = 1'b0;
  int unsigned src_gap        = 0;
  int unsigned sink_gap       = 0;
  int unsigned hold_left      = 0;
  int unsigned cycle_count    = 0;
  int unsigned bytes_queued   = 0;
  int unsigned packets_judged = 0;
  int unsigned settings_used  = 0;
  int unsigned errors         = 0;
  int unsigned kind_tally[4]  = '{0, 0, 0, 0};

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned next_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void clear_packet_state();
    trk_phase   = SEEK_LEN;
    trk_len     = '0;
    trk_left    = '0;
    trk_type    = '0;
    trk_head    = '0;
    trk_stopped = 1'b0;
    trk_found   = KIND_NONE;
    trk_count   = '0;
  endfunction

  function automatic void judge_structure();
    logic [IdW-1:0]   id;
    logic [ByteW-1:0] third;
    id    = trk_head[15:0];
    third = trk_head[23:16];
    if (trk_found != KIND_NONE) return;
    if (trk_type == TypeMfrData && trk_len >= MfrMinLen) begin
      if (id == cfg_model.findmy_id && third == cfg_model.findmy_sub) begin
        trk_found = KIND_FINDMY;
      end else if (id == cfg_model.tag_id) begin
        trk_found = KIND_VENDOR;
      end
    end
    if (trk_found == KIND_NONE && trk_type == TypeSvcData && trk_len >= SvcMinLen &&
        (id == cfg_model.uuid_a || id == cfg_model.uuid_b)) begin
      trk_found = KIND_SERVICE;
    end
  endfunction

  function automatic void classify_byte(logic [ByteW-1:0] b, logic last);
    logic [ByteW-1:0] pos;
    verdict_t         v;
    if (trk_count != MaxParsed) begin
      if (!trk_stopped) begin
        case (trk_phase)
          SEEK_LEN: begin
            if (b == 8'h00) begin
              trk_stopped = 1'b1;
            end else begin
              trk_len   = b - 8'd1;
              trk_left  = trk_len;
              trk_head  = '0;
              trk_phase = SEEK_TYPE;
            end
          end
          SEEK_TYPE: begin
            trk_type = b;
            if (trk_left == 0) begin
              judge_structure();
              trk_phase = SEEK_LEN;
            end else begin
              trk_phase = IN_BODY;
            end
          end
          default: begin
            pos = trk_len - trk_left;
            if (pos < 3) trk_head = trk_head | (HeadW'(b) << (pos * 8));
            trk_left = trk_left - 8'd1;
            if (trk_left == 0) begin
              judge_structure();
              trk_phase = SEEK_LEN;
            end
          end
        endcase
      end
      trk_count = trk_count + 8'd1;
    end
    if (last) begin
      v.found = (trk_found != KIND_NONE);
      v.kind  = trk_found;
      verdicts_due.push_back(v);
      kind_tally[int'(trk_found)]++;
      packets_judged++;
      clear_packet_state();
    end
  endfunction

  function automatic void flush_packet();
    adv_item_t it;
    foreach (pkt_bytes[k]) begin
      it.value = pkt_bytes[k];
      it.last  = (k == pkt_bytes.size() - 1);
      bytes_pending.push_back(it);
    end
    bytes_queued += pkt_bytes.size();
    pkt_bytes.delete();
  endfunction

  function automatic void add_random_structure();
    int unsigned      r;
    int unsigned      plen;
    logic [ByteW-1:0] stype;
    logic [ByteW-1:0] third;
    logic [IdW-1:0]   id;
    r = $urandom_range(0, 9);
    stype = (r < 4) ? TypeMfrData : (r < 7) ? TypeSvcData : 8'($urandom);
    r = $urandom_range(0, 99);
    if (r < 30) id = cfg_model.findmy_id;
    else if (r < 50) id = cfg_model.tag_id;
    else if (r < 65) id = cfg_model.uuid_a;
    else if (r < 80) id = cfg_model.uuid_b;
    else id = 16'($urandom);
    if ($urandom_range(0, 9) == 0) id = id ^ (16'd1 << $urandom_range(0, 15));
    third = ($urandom_range(0, 2) != 0) ? cfg_model.findmy_sub : 8'($urandom);
    r = $urandom_range(0, 99);
    if (r < 75) plen = $urandom_range(0, 6);
    else if (r < 97) plen = $urandom_range(7, 20);
    else plen = $urandom_range(21, 254);
    pkt_bytes.push_back(8'(plen + 1));
    pkt_bytes.push_back(stype);
    for (int unsigned k = 0; k < plen; k++) begin
      if (k == 0) pkt_bytes.push_back(id[7:0]);
      else if (k == 1) pkt_bytes.push_back(id[15:8]);
      else if (k == 2) pkt_bytes.push_back(third);
      else pkt_bytes.push_back(8'($urandom));
    end
  endfunction

  function automatic void queue_random_packet();
    int unsigned pick;
    int unsigned cut;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 16)) pkt_bytes.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 4)) add_random_structure();
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        cut = $urandom_range(1, (pkt_bytes.size() > 6) ? 6 : pkt_bytes.size() - 1);
        repeat (cut) void'(pkt_bytes.pop_back());
      end else if (pick < 22) begin
        pkt_bytes.push_back(8'h00);
        if ($urandom_range(0, 1) == 1) add_random_structure();
        repeat ($urandom_range(0, 4)) pkt_bytes.push_back(8'($urandom));
      end else if (pick < 27) begin
        repeat ($urandom_range(1, 3)) pkt_bytes.push_back(8'($urandom));
      end
    end
    flush_packet();
  endfunction

  function automatic void run_random(int unsigned budget);
    int unsigned goal;
    goal = bytes_queued + budget;
    while (bytes_queued < goal) queue_random_packet();
  endfunction

  function automatic void queue_long_packet(logic [ByteW-1:0] tail[$]);
    repeat (84 - (tail.size() > 4 ? 1 : 0)) begin
      pkt_bytes.push_back(8'h02);
      pkt_bytes.push_back(8'h01);
      pkt_bytes.push_back(8'($urandom));
    end
    foreach (tail[k]) pkt_bytes.push_back(tail[k]);
    repeat (40) pkt_bytes.push_back(8'($urandom));
    pkt_bytes.push_back(8'h03);
    pkt_bytes.push_back(TypeSvcData);
    pkt_bytes.push_back(cfg_model.uuid_a[7:0]);
    pkt_bytes.push_back(cfg_model.uuid_a[15:8]);
    flush_packet();
  endfunction

  task automatic wait_idle();
    while (bytes_pending.size() != 0 || adv_if.valid || verdicts_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      REG_FINDMY_ID:  cfg_model.findmy_id  = value;
      REG_FINDMY_SUB: cfg_model.findmy_sub = value[7:0];
      REG_TAG_ID:     cfg_model.tag_id     = value;
      REG_UUID_A:     cfg_model.uuid_a     = value;
      default:        cfg_model.uuid_b     = value;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic apply_setting(logic [IdW-1:0] findmy_id, logic [ByteW-1:0] findmy_sub,
                               logic [IdW-1:0] tag_id, logic [IdW-1:0] uuid_a,
                               logic [IdW-1:0] uuid_b);
    write_reg(REG_FINDMY_ID, findmy_id);
    write_reg(REG_FINDMY_SUB, {8'h00, findmy_sub});
    write_reg(REG_TAG_ID, tag_id);
    write_reg(REG_UUID_A, uuid_a);
    write_reg(REG_UUID_B, uuid_b);
    settings_used++;
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && (!adv_if.valid || adv_fire)) begin
      if (src_gap != 0) begin
        src_gap = src_gap - 1;
        adv_if.valid <= 1'b0;
      end else if (bytes_pending.size() != 0) begin
        next_item = bytes_pending.pop_front();
        adv_if.valid         <= 1'b1;
        adv_if.adv_byte      <= next_item.value;
        adv_if.end_of_packet <= next_item.last;
        if (!sender_quiet) src_gap = next_gap();
      end else begin
        adv_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_off_req) begin
        hold_left    = LongHold;
        hold_off_req = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        res_if.ready <= 1'b0;
      end else if (sink_gap != 0) begin
        sink_gap = sink_gap - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        if (!receiver_quiet) sink_gap = next_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    verdict_t want;
    adv_fire <= adv_if.valid && adv_if.ready;
    if (rst_ni) begin
      if (adv_if.valid && adv_if.ready) begin
        classify_byte(adv_if.adv_byte, adv_if.end_of_packet);
      end
      if (res_if.valid && res_if.ready) begin
        if (verdicts_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result found=%0d kind=%0d", $time,
                   res_if.tracker_found, res_if.tracker_kind);
        end else begin
          want = verdicts_due.pop_front();
          if (res_if.tracker_found !== want.found) begin
            errors++;
            $display("%0t: tracker_found expected %0d actual %0d", $time,
                     want.found, res_if.tracker_found);
          end
          if (res_if.tracker_kind !== want.kind) begin
            errors++;
            $display("%0t: tracker_kind expected %0d actual %0d", $time,
                     want.kind, res_if.tracker_kind);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("%0t: timeout with %0d bytes and %0d results outstanding", $time,
               bytes_pending.size(), verdicts_due.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [IdW-1:0]   same_id;
    logic [ByteW-1:0] same_sub;
    logic [IdW-1:0]   same_uuid;
    rst_ni               = 1'b0;
    adv_if.valid         = 1'b0;
    adv_if.adv_byte      = '0;
    adv_if.end_of_packet = 1'b0;
    res_if.ready         = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = REG_FINDMY_ID;
    cfg_if.data          = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset register values: one packet per signature kind, the length
    // thresholds, a zero length stop, a structure cut by the packet end,
    // a late match behind an earlier one, and the 255-byte parse limit.
    pkt_bytes = {8'h03, 8'h16, 8'hED, 8'hFE};
    flush_packet();
    pkt_bytes = {8'h05, 8'hFF, 8'h75, 8'h00, 8'hAB, 8'hCD};
    flush_packet();
    pkt_bytes = {8'h05, 8'hFF, 8'h4C, 8'h00, 8'h12, 8'h00};
    flush_packet();
    pkt_bytes = {8'h04, 8'hFF, 8'h4C, 8'h00, 8'h12, 8'h02, 8'h16, 8'h84};
    flush_packet();
    pkt_bytes = {8'h00, 8'h03, 8'h16, 8'h84, 8'hFD};
    flush_packet();
    pkt_bytes = {8'h06, 8'hFF, 8'h4C, 8'h00, 8'h12};
    flush_packet();
    pkt_bytes = {8'h03, 8'h16, 8'h84, 8'hFD, 8'h05, 8'hFF, 8'h75, 8'h00, 8'h00, 8'h00};
    flush_packet();
    pkt_bytes = {8'hFF};
    flush_packet();
    queue_long_packet({8'h03, 8'h16, 8'hED, 8'hFE});
    queue_long_packet({8'h05, 8'hFF, 8'h75, 8'h00, 8'h11, 8'h22});
    run_random(40);
    wait_idle();

    apply_setting(16'h0000, 8'h00, 16'h0000, 16'h0000, 16'h0000);
    run_random(40);
    wait_idle();

    // The result side stalls for a long stretch while short packets keep
    // coming, so the output register fills and the byte input backs up.
    apply_setting(16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    sender_quiet = 1'b1;
    hold_off_req = 1'b1;
    pkt_bytes = {8'h00};
    flush_packet();
    pkt_bytes = {8'h00};
    flush_packet();
    run_random(80);
    while (bytes_pending.size() != 0) @(posedge clk_i);
    sender_quiet = 1'b0;
    wait_idle();

    // Equal company IDs: the find-my check must win over the vendor check.
    same_id   = 16'($urandom);
    same_sub  = 8'($urandom);
    same_uuid = 16'($urandom);
    apply_setting(same_id, same_sub, same_id, same_uuid, same_uuid);
    pkt_bytes = {8'h05, TypeMfrData, same_id[7:0], same_id[15:8], same_sub, 8'h00};
    flush_packet();
    pkt_bytes = {8'h05, TypeMfrData, same_id[7:0], same_id[15:8], ~same_sub, 8'h00};
    flush_packet();
    sender_quiet   = 1'b1;
    receiver_quiet = 1'b1;
    run_random(40);
    wait_idle();
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;

    apply_setting(16'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    run_random(30);
    wait_idle();
    run_random(30);
    wait_idle();

    apply_setting(16'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    run_random(40);
    wait_idle();

    apply_setting(RstFindmyId, RstFindmySub, RstTagId, RstUuidA, RstUuidB);
    run_random(40);
    wait_idle();

    $display("Run covered %0d advertisement bytes in %0d packets over %0d register settings.",
             bytes_queued, packets_judged, settings_used + 1);
    $display("Verdicts: %0d none, %0d find-my, %0d vendor, %0d service-data.",
             kind_tally[0], kind_tally[1], kind_tally[2], kind_tally[3]);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[ble_adv_tracker_classifier.f]
sv/blat_pkg.sv
sv/blat_if.sv
sv/blat_cfg_regs.sv
sv/blat_parser.sv
sv/ble_adv_tracker_classifier.sv
tb/tb_top.sv
